// ----- rtl/lphs_pkg.sv -----
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types, codes and sizes for the linear probing hash set core.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

    // Default sizes for the top level parameters.
    localparam int SLOTS_DEF       = 26;
    localparam int MAX_LETTERS_DEF = 12;

    // Fixed field widths of the request and response beats, the live count width and the alphabet size.
    localparam int LETTER_W = 5;
    localparam int CHARS_W  = 60;
    localparam int LEN_W    = 4;
    localparam int IDX_W    = 5;
    localparam int LIVE_W   = 5;
    localparam int ALPHABET = 26;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_DUMP   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_DELETED   = 3'd5,
        ST_DUMP      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        MARK_UNUSED = 2'd0,
        MARK_TOMB   = 2'd1,
        MARK_OCC    = 2'd2
    } mark_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [CHARS_W-1:0] key_chars;
        logic [LEN_W-1:0]   key_length;
    } req_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [IDX_W-1:0]   slot_index;
        logic [1:0]         slot_state;
        logic [CHARS_W-1:0] stored_chars;
        logic [LEN_W-1:0]   stored_length;
        logic               last_of_run;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic issue_rd;
        logic find_step;
        logic set_noslot;
        logic out_from_res;
        logic out_from_dump;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dump;
        logic no_slot;
        logic find_stop;
        logic dump_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/linear_probe_hash_set_core.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// Insert, delete and search probe k slots (1..SLOTS) between the request
// beat and the response beat. A request with a bad key, or an insert into a
// full table, skips the probe walk. Throughput: one request at a time; a
// dump streams SLOTS beats, one a cycle while the response side takes them.
// Reset: rst_n clears every slot to unused and the live count to zero at once.
// ----------------------------------------------------------------------------
`default_nettype none

// The probe walk reads one slot per cycle from the key store, whose read
// data is registered, so the compare for a slot happens in the cycle after
// its address is issued. The walk length therefore sets the request time.
// The response sits in an output register, so the next request can be
// accepted while the previous response still waits to be taken.
module linear_probe_hash_set_core #(
    parameter int SLOTS       = lphs_pkg::SLOTS_DEF,
    parameter int MAX_LETTERS = lphs_pkg::MAX_LETTERS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  lphs_pkg::req_item_t     req_item,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output lphs_pkg::rsp_item_t     rsp_item
);

    // Commands and status between the sequencer and the datapath.
    lphs_pkg::ctl_cmd_t cmd;
    lphs_pkg::dp_stat_t stat;

    // The sequencer decides which step runs each cycle: accept a beat,
    // decode it, walk the probe sequence, hand off a result, or stream
    // the dump beats while the response side keeps taking them.
    lphs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the slot marks in flops (so reset clears them),
    // the key letters in a memory whose data is used only behind an occupied
    // mark, the live count, the probe pointer and the response register.
    lphs_dp #(
        .SLOTS       (SLOTS),
        .MAX_LETTERS (MAX_LETTERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item)
    );

endmodule

`default_nettype wire

// ----- rtl/lphs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lphs_ctrl
// Sequencer that steps one request through decode, probe walk or dump.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  lphs_pkg::dp_stat_t      stat,
    output lphs_pkg::ctl_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_FIND   = 5'b00100,
        S_EMIT   = 5'b01000,
        S_DUMP   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_dump)
                begin
                    cmd.issue_rd = 1'b1;
                    state_next   = S_DUMP;
                end
                else if (stat.no_slot)
                begin
                    cmd.set_noslot = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.issue_rd = 1'b1;
                    state_next   = S_FIND;
                end
            end
            S_FIND:
            begin
                // The read issued on the stopping cycle is simply dropped.
                cmd.issue_rd  = 1'b1;
                cmd.find_step = 1'b1;
                if (stat.find_stop)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_from_res = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_from_dump = 1'b1;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.issue_rd = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lphs_dp.sv -----
// ----------------------------------------------------------------------------
// lphs_dp
// Key decode, slot storage, probe compare, live count and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_dp #(
    parameter int SLOTS       = lphs_pkg::SLOTS_DEF,
    parameter int MAX_LETTERS = lphs_pkg::MAX_LETTERS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  lphs_pkg::req_item_t     req_item,
    input  lphs_pkg::ctl_cmd_t      cmd,
    output lphs_pkg::dp_stat_t      stat,
    input  wire logic               rsp_ready,
    output logic                    rsp_valid,
    output lphs_pkg::rsp_item_t     rsp_item
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = MAX_LETTERS * lphs_pkg::LETTER_W;
    localparam int DW = CW + lphs_pkg::LEN_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // Request decode.
    logic [lphs_pkg::LEN_W-1:0]    req_len;
    logic                          len_ok;
    logic                          letters_ok;
    logic [CW-1:0]                 key_masked;
    logic [lphs_pkg::LETTER_W-1:0] last_letter;
    logic [IW-1:0]                 home;

    // Latched request.
    logic [1:0]                    action_reg;
    logic [CW-1:0]                 key_reg;
    logic [lphs_pkg::LEN_W-1:0]    len_reg;
    logic                          valid_reg;

    // Walk state.
    logic [IW-1:0]                 ptr_reg;
    logic [IW-1:0]                 cnt_reg;
    logic                          free_found_reg;
    logic [IW-1:0]                 free_idx_reg;
    logic [lphs_pkg::LIVE_W-1:0]   live_reg;

    // Slot storage.
    lphs_pkg::mark_t               mark_reg [SLOTS];
    logic [DW-1:0]                 slot_mem [SLOTS];
    logic [DW-1:0]                 rd_data_reg;
    lphs_pkg::mark_t               rd_mark_reg;
    logic [IW-1:0]                 rd_idx_reg;

    // Results.
    lphs_pkg::rsp_item_t           res_reg;
    lphs_pkg::rsp_item_t           out_reg;
    logic                          out_valid_reg;
    lphs_pkg::rsp_item_t           find_res;
    lphs_pkg::rsp_item_t           noslot_res;
    lphs_pkg::rsp_item_t           dump_res;

    logic [CW-1:0]                 rd_chars;
    logic [lphs_pkg::LEN_W-1:0]    rd_len;
    logic                          rd_occ;
    logic                          rd_match;
    logic                          find_stop;
    logic                          eff_free_found;
    logic [IW-1:0]                 eff_free_idx;
    logic                          ins_now;
    logic                          del_now;

    always_comb
    begin
        req_len     = req_item.key_length;
        len_ok      = (req_len >= lphs_pkg::LEN_W'(1)) &&
                      (req_len <= lphs_pkg::LEN_W'(MAX_LETTERS));
        letters_ok  = 1'b1;
        key_masked  = '0;
        last_letter = '0;
        for (int i = 0; i < MAX_LETTERS; i++)
        begin
            if (lphs_pkg::LEN_W'(i) < req_len)
            begin
                key_masked[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W] =
                    req_item.key_chars[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W];
                if (req_item.key_chars[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W] >=
                    lphs_pkg::LETTER_W'(lphs_pkg::ALPHABET))
                begin
                    letters_ok = 1'b0;
                end
            end
            if (lphs_pkg::LEN_W'(i + 1) == req_len)
            begin
                last_letter =
                    req_item.key_chars[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W];
            end
        end
        // Home slot is the last letter folded into the slot range.
        home = '0;
        for (int v = 0; v < (1 << lphs_pkg::LETTER_W); v++)
        begin
            if (last_letter == lphs_pkg::LETTER_W'(v))
            begin
                home = IW'(v % SLOTS);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= req_item.action;
            key_reg    <= key_masked;
            len_reg    <= req_len;
            valid_reg  <= len_ok && letters_ok;
        end
    end

    // Probe compare on the slot read in the previous cycle.
    always_comb
    begin
        rd_chars       = rd_data_reg[CW-1:0];
        rd_len         = rd_data_reg[CW +: lphs_pkg::LEN_W];
        rd_occ         = (rd_mark_reg == lphs_pkg::MARK_OCC);
        rd_match       = rd_occ && (rd_chars == key_reg) && (rd_len == len_reg);
        find_stop      = (rd_mark_reg == lphs_pkg::MARK_UNUSED) || rd_match ||
                         (cnt_reg == LAST_IDX);
        eff_free_found = free_found_reg || !rd_occ;
        eff_free_idx   = free_found_reg ? free_idx_reg : rd_idx_reg;
        ins_now        = cmd.find_step && find_stop && !rd_match &&
                         (action_reg == lphs_pkg::ACT_INSERT) && eff_free_found;
        del_now        = cmd.find_step && find_stop && rd_match &&
                         (action_reg == lphs_pkg::ACT_DELETE);
    end

    always_comb
    begin
        find_res             = '0;
        find_res.last_of_run = 1'b1;
        if (rd_match)
        begin
            find_res.slot_index = lphs_pkg::IDX_W'(rd_idx_reg);
            case (action_reg)
                lphs_pkg::ACT_INSERT:
                begin
                    find_res.status        = lphs_pkg::ST_DUPLICATE;
                    find_res.slot_state    = lphs_pkg::MARK_OCC;
                    find_res.stored_chars  = lphs_pkg::CHARS_W'(rd_chars);
                    find_res.stored_length = rd_len;
                end
                lphs_pkg::ACT_DELETE:
                begin
                    find_res.status     = lphs_pkg::ST_DELETED;
                    find_res.slot_state = lphs_pkg::MARK_TOMB;
                end
                default:
                begin
                    find_res.status        = lphs_pkg::ST_FOUND;
                    find_res.slot_state    = lphs_pkg::MARK_OCC;
                    find_res.stored_chars  = lphs_pkg::CHARS_W'(rd_chars);
                    find_res.stored_length = rd_len;
                end
            endcase
        end
        else if (action_reg == lphs_pkg::ACT_INSERT)
        begin
            if (eff_free_found)
            begin
                find_res.status        = lphs_pkg::ST_INSERTED;
                find_res.slot_index    = lphs_pkg::IDX_W'(eff_free_idx);
                find_res.slot_state    = lphs_pkg::MARK_OCC;
                find_res.stored_chars  = lphs_pkg::CHARS_W'(key_reg);
                find_res.stored_length = len_reg;
            end
            else
            begin
                find_res.status = lphs_pkg::ST_FULL;
            end
        end
        else
        begin
            find_res.status = lphs_pkg::ST_NOT_FOUND;
        end
    end

    always_comb
    begin
        noslot_res             = '0;
        noslot_res.status      = (action_reg == lphs_pkg::ACT_INSERT) ?
                                 lphs_pkg::ST_FULL : lphs_pkg::ST_NOT_FOUND;
        noslot_res.last_of_run = 1'b1;

        dump_res               = '0;
        dump_res.status        = lphs_pkg::ST_DUMP;
        dump_res.slot_index    = lphs_pkg::IDX_W'(rd_idx_reg);
        dump_res.slot_state    = rd_mark_reg;
        dump_res.last_of_run   = (rd_idx_reg == LAST_IDX);
        if (rd_occ)
        begin
            dump_res.stored_chars  = lphs_pkg::CHARS_W'(rd_chars);
            dump_res.stored_length = rd_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                ptr_reg <= (req_item.action == lphs_pkg::ACT_DUMP) ? '0 : home;
            end
            else if (cmd.issue_rd)
            begin
                ptr_reg <= (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IW'(1);
            end

            if (cmd.load_item)
            begin
                cnt_reg        <= '0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.find_step && !find_stop)
            begin
                cnt_reg <= cnt_reg + IW'(1);
                if (!rd_occ && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
            end

            if (ins_now)
            begin
                live_reg <= live_reg + lphs_pkg::LIVE_W'(1);
            end
            else if (del_now && (live_reg != '0))
            begin
                live_reg <= live_reg - lphs_pkg::LIVE_W'(1);
            end

            if (cmd.out_from_res || cmd.out_from_dump)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                mark_reg[s] <= lphs_pkg::MARK_UNUSED;
            end
        end
        else
        begin
            if (ins_now)
            begin
                mark_reg[eff_free_idx] <= lphs_pkg::MARK_OCC;
            end
            if (del_now)
            begin
                mark_reg[rd_idx_reg] <= lphs_pkg::MARK_TOMB;
            end
        end
    end

    // Key storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ins_now)
        begin
            slot_mem[eff_free_idx] <= {len_reg, key_reg};
        end
        if (cmd.issue_rd)
        begin
            rd_data_reg <= slot_mem[ptr_reg];
            rd_mark_reg <= mark_reg[ptr_reg];
            rd_idx_reg  <= ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_noslot)
        begin
            res_reg <= noslot_res;
        end
        else if (cmd.find_step && find_stop)
        begin
            res_reg <= find_res;
        end

        if (cmd.out_from_res)
        begin
            out_reg <= res_reg;
        end
        else if (cmd.out_from_dump)
        begin
            out_reg <= dump_res;
        end
    end

    always_comb
    begin
        stat.is_dump   = (action_reg == lphs_pkg::ACT_DUMP);
        stat.no_slot   = !valid_reg ||
                         ((action_reg == lphs_pkg::ACT_INSERT) &&
                          (live_reg >= lphs_pkg::LIVE_W'(SLOTS)));
        stat.find_stop = find_stop;
        stat.dump_last = (rd_idx_reg == LAST_IDX);
        stat.out_free  = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/lphs_checker.sv -----
// ----------------------------------------------------------------------------
// lphs_checker
// Port level checks for the hash set core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_checker #(
    parameter int SLOTS = lphs_pkg::SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_ready,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_ready,
    input  lphs_pkg::rsp_item_t     rsp_item
);

    // A stalled response beat holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("response beat changed while stalled");

    // Requests are handled one at a time.
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // Dump beats follow one another without a gap when not stalled.
    a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_item.last_of_run |=> rsp_valid)
        else $error("gap inside a dump run");

    // The dump run ends on the top slot.
    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status == lphs_pkg::ST_DUMP) && rsp_item.last_of_run
        |-> rsp_item.slot_index == lphs_pkg::IDX_W'(SLOTS - 1))
        else $error("dump run ended on the wrong slot");

    // Every response other than a dump beat closes its run.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status != lphs_pkg::ST_DUMP)
        |-> rsp_item.last_of_run)
        else $error("single response without end of run");

endmodule

bind linear_probe_hash_set_core lphs_checker #(
    .SLOTS (SLOTS)
) u_lphs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
);

`default_nettype wire
